// ===== src/gpt_pkg.sv =====
package gpt_pkg;

    // mode register codes; codes above MODE_HT_WHITE pass the pixel through
    localparam logic [2:0] MODE_NEGATIVE = 3'd0;
    localparam logic [2:0] MODE_LEVELS   = 3'd1;
    localparam logic [2:0] MODE_THRESH   = 3'd2;
    localparam logic [2:0] MODE_HT_BLACK = 3'd3;
    localparam logic [2:0] MODE_HT_WHITE = 3'd4;

    // configuration register indexes
    localparam logic [2:0] CFG_MODE      = 3'd0;
    localparam logic [2:0] CFG_MAX_GREY  = 3'd1;
    localparam logic [2:0] CFG_BLACK     = 3'd2;
    localparam logic [2:0] CFG_WHITE     = 3'd3;
    localparam logic [2:0] CFG_THRESHOLD = 3'd4;

    localparam int unsigned FIELD_BITS = 16;
    localparam int unsigned CFG_BITS   = 16;
    localparam int unsigned IDX_BITS   = 3;

    // side information that travels with each pixel down the pipe
    typedef struct packed {
        logic valid;
        logic line_end;
        logic frame_end;
        logic use_div;   // result comes from the divider, not the bypass value
    } t_side;

endpackage

// ===== src/gpt_map.sv =====
module gpt_map #(
    parameter int unsigned PIXEL_BITS = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  gpt_pkg::t_side          i_side,
    input  logic [PIXEL_BITS-1:0]   i_pix,
    input  logic [2:0]              i_mode,
    input  logic [PIXEL_BITS-1:0]   i_max,
    input  logic [PIXEL_BITS-1:0]   i_black,
    input  logic [PIXEL_BITS-1:0]   i_white,
    input  logic [PIXEL_BITS-1:0]   i_thresh,
    output gpt_pkg::t_side          o_side,
    output logic [PIXEL_BITS-1:0]   o_res,
    output logic [PIXEL_BITS-1:0]   o_diff,
    output logic [PIXEL_BITS-1:0]   o_den
);
    import gpt_pkg::*;

    t_side                 r_side;
    t_side                 n_side;
    logic                  n_use_div;
    logic [PIXEL_BITS-1:0] n_res;
    logic [PIXEL_BITS-1:0] r_res;
    logic [PIXEL_BITS-1:0] r_diff;
    logic [PIXEL_BITS-1:0] r_den;
    logic                  w_le_t;

    assign w_le_t = (i_pix <= i_thresh);

    always_comb begin
        n_use_div = 1'b0;
        case (i_mode)
            MODE_NEGATIVE: n_res = (i_pix <= i_max) ? (i_max - i_pix) : '0;
            MODE_LEVELS: begin
                if (i_pix <= i_black) begin
                    n_res = '0;
                end else if (i_pix < i_white) begin
                    n_res     = '0;
                    n_use_div = 1'b1;
                end else begin
                    n_res = i_max;
                end
            end
            MODE_THRESH:   n_res = w_le_t ? '0 : i_max;
            MODE_HT_BLACK: n_res = w_le_t ? '0 : i_pix;
            MODE_HT_WHITE: n_res = w_le_t ? i_pix : i_max;
            default:       n_res = i_pix;
        endcase
    end

    always_comb begin
        n_side         = i_side;
        n_side.use_div = n_use_div;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side <= '0;
        end else if (i_en) begin
            r_side <= n_side;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_res  <= n_res;
            r_diff <= i_pix - i_black;
            r_den  <= i_white - i_black;
        end
    end

    assign o_side = r_side;
    assign o_res  = r_res;
    assign o_diff = r_diff;
    assign o_den  = r_den;

endmodule

// ===== src/gpt_mul.sv =====
module gpt_mul #(
    parameter int unsigned PIXEL_BITS = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  gpt_pkg::t_side            i_side,
    input  logic [PIXEL_BITS-1:0]     i_res,
    input  logic [PIXEL_BITS-1:0]     i_diff,
    input  logic [PIXEL_BITS-1:0]     i_den,
    input  logic [PIXEL_BITS-1:0]     i_max,
    output gpt_pkg::t_side            o_side,
    output logic [PIXEL_BITS-1:0]     o_res,
    output logic [2*PIXEL_BITS-1:0]   o_prod,
    output logic [PIXEL_BITS-1:0]     o_den
);
    import gpt_pkg::*;

    t_side                   r_side;
    logic [PIXEL_BITS-1:0]   r_res;
    logic [2*PIXEL_BITS-1:0] r_prod;
    logic [PIXEL_BITS-1:0]   r_den;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side <= '0;
        end else if (i_en) begin
            r_side <= i_side;
        end
    end

    // (pixel - black) * max, full width
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_res  <= i_res;
            r_prod <= (2*PIXEL_BITS)'(i_diff) * (2*PIXEL_BITS)'(i_max);
            r_den  <= i_den;
        end
    end

    assign o_side = r_side;
    assign o_res  = r_res;
    assign o_prod = r_prod;
    assign o_den  = r_den;

endmodule

// ===== src/gpt_div_stage.sv =====
// One restoring division step. i_work holds {remainder, numerator bits
// still to consume}; quotient bits shift in at the bottom.
module gpt_div_stage #(
    parameter int unsigned PIXEL_BITS = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  gpt_pkg::t_side            i_side,
    input  logic [PIXEL_BITS-1:0]     i_res,
    input  logic [2*PIXEL_BITS-1:0]   i_work,
    input  logic [PIXEL_BITS-1:0]     i_den,
    output gpt_pkg::t_side            o_side,
    output logic [PIXEL_BITS-1:0]     o_res,
    output logic [2*PIXEL_BITS-1:0]   o_work,
    output logic [PIXEL_BITS-1:0]     o_den
);
    import gpt_pkg::*;

    t_side                   r_side;
    logic [PIXEL_BITS-1:0]   r_res;
    logic [2*PIXEL_BITS-1:0] r_work;
    logic [PIXEL_BITS-1:0]   r_den;

    logic [PIXEL_BITS:0]     w_trial;
    logic                    w_ge;
    logic [PIXEL_BITS:0]     w_sub;
    logic [PIXEL_BITS-1:0]   n_rem;
    logic [2*PIXEL_BITS-1:0] n_work;

    assign w_trial = i_work[2*PIXEL_BITS-1:PIXEL_BITS-1];
    assign w_ge    = (w_trial >= {1'b0, i_den});
    assign w_sub   = w_trial - {1'b0, i_den};
    assign n_rem   = w_ge ? w_sub[PIXEL_BITS-1:0] : w_trial[PIXEL_BITS-1:0];
    assign n_work  = {n_rem, i_work[PIXEL_BITS-2:0], w_ge};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side <= '0;
        end else if (i_en) begin
            r_side <= i_side;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_res  <= i_res;
            r_work <= n_work;
            r_den  <= i_den;
        end
    end

    assign o_side = r_side;
    assign o_res  = r_res;
    assign o_work = r_work;
    assign o_den  = r_den;

endmodule

// ===== src/grey_point_transform.sv =====
// Greyscale point operation on a pixel stream.
// Slave stream carries one pixel per word, with the row-end marker on tlast
// and the image-end marker on tuser. Master stream gives one word per input
// word, in order, markers copied unchanged.
// Five registers are written through the cfg port (mode, max grey, black
// level, white level, threshold); write them only while the pipe is empty.
// Grey values are taken in their low PIXEL_BITS bits.
// Throughput: one word per cycle unless the receiver stalls. A word
// passes, in order, the input register, decode, multiply, one stage per
// quotient bit of the levels divider and the output register. The
// divider is fully pipelined, so every mode has the same latency and
// the depth is set by the number of quotient bits.
// Reset clears every valid bit and loads the register reset values
// (negative mode, max 255, black 0, white 255, threshold 127).
// When the receiver stalls with a word waiting, the whole pipe holds and
// s_axis_tready drops; nothing is lost or repeated. While the output
// register is empty the pipe keeps moving even if the receiver is stalled.
module grey_point_transform #(
    parameter int unsigned PIXEL_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // slave side
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [gpt_pkg::FIELD_BITS-1:0]    s_axis_tdata,  // [15:0] pixel_in
    input  logic                              s_axis_tlast,  // line_end_in
    input  logic                              s_axis_tuser,  // [0] frame_end_in
    // master side
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [gpt_pkg::FIELD_BITS-1:0]    m_axis_tdata,  // [15:0] pixel_out
    output logic                              m_axis_tlast,  // line_end_out
    output logic                              m_axis_tuser,  // [0] frame_end_out
    // configuration writes
    input  logic                              i_cfg_we,
    input  logic [gpt_pkg::IDX_BITS-1:0]      i_cfg_idx,
    input  logic [gpt_pkg::CFG_BITS-1:0]      i_cfg_data
);
    import gpt_pkg::*;

    localparam int unsigned PB = PIXEL_BITS;

    // configuration registers
    logic [2:0]          r_mode;
    logic [CFG_BITS-1:0] r_max;
    logic [CFG_BITS-1:0] r_black;
    logic [CFG_BITS-1:0] r_white;
    logic [CFG_BITS-1:0] r_thresh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_NEGATIVE;
            r_max    <= CFG_BITS'(255);
            r_black  <= '0;
            r_white  <= CFG_BITS'(255);
            r_thresh <= CFG_BITS'(127);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MODE:      r_mode   <= i_cfg_data[2:0];
                CFG_MAX_GREY:  r_max    <= i_cfg_data;
                CFG_BLACK:     r_black  <= i_cfg_data;
                CFG_WHITE:     r_white  <= i_cfg_data;
                CFG_THRESHOLD: r_thresh <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // single advance enable: pipe moves whenever the output register frees up
    logic w_adv;
    logic r_out_valid;

    assign w_adv         = !r_out_valid || m_axis_tready;
    assign s_axis_tready = w_adv;

    // input register
    t_side         r_in_side;
    logic [PB-1:0] r_in_pix;
    t_side         n_in_side;

    always_comb begin
        n_in_side           = '0;
        n_in_side.valid     = s_axis_tvalid;
        n_in_side.line_end  = s_axis_tlast;
        n_in_side.frame_end = s_axis_tuser;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_side <= '0;
        end else if (w_adv) begin
            r_in_side <= n_in_side;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_in_pix <= s_axis_tdata[PB-1:0];
        end
    end

    // decode stage: bypass result and levels operands
    t_side         w_map_side;
    logic [PB-1:0] w_map_res;
    logic [PB-1:0] w_map_diff;
    logic [PB-1:0] w_map_den;

    gpt_map #(.PIXEL_BITS(PB)) u_map (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_adv),
        .i_side   (r_in_side),
        .i_pix    (r_in_pix),
        .i_mode   (r_mode),
        .i_max    (r_max[PB-1:0]),
        .i_black  (r_black[PB-1:0]),
        .i_white  (r_white[PB-1:0]),
        .i_thresh (r_thresh[PB-1:0]),
        .o_side   (w_map_side),
        .o_res    (w_map_res),
        .o_diff   (w_map_diff),
        .o_den    (w_map_den)
    );

    // divider chain, index 0 is the multiplier output
    t_side           w_side [0:PB];
    logic [PB-1:0]   w_res  [0:PB];
    logic [2*PB-1:0] w_work [0:PB];
    logic [PB-1:0]   w_den  [0:PB];

    gpt_mul #(.PIXEL_BITS(PB)) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_side  (w_map_side),
        .i_res   (w_map_res),
        .i_diff  (w_map_diff),
        .i_den   (w_map_den),
        .i_max   (r_max[PB-1:0]),
        .o_side  (w_side[0]),
        .o_res   (w_res[0]),
        .o_prod  (w_work[0]),
        .o_den   (w_den[0])
    );

    // the quotient is below max grey, so it fits in PB bits and the
    // upper half of the product starts below the divisor
    for (genvar g = 0; g < PB; g++) begin : g_div
        gpt_div_stage #(.PIXEL_BITS(PB)) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_adv),
            .i_side  (w_side[g]),
            .i_res   (w_res[g]),
            .i_work  (w_work[g]),
            .i_den   (w_den[g]),
            .o_side  (w_side[g+1]),
            .o_res   (w_res[g+1]),
            .o_work  (w_work[g+1]),
            .o_den   (w_den[g+1])
        );
    end

    // output register
    logic [PB-1:0] r_out_pix;
    logic          r_out_le;
    logic          r_out_fe;
    logic [PB-1:0] n_out_pix;

    assign n_out_pix = w_side[PB].use_div ? w_work[PB][PB-1:0] : w_res[PB];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= w_side[PB].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_pix <= n_out_pix;
            r_out_le  <= w_side[PB].line_end;
            r_out_fe  <= w_side[PB].frame_end;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = FIELD_BITS'(r_out_pix);
    assign m_axis_tlast  = r_out_le;
    assign m_axis_tuser  = r_out_fe;

endmodule

// ===== dv/grey_point_checker.sv =====
module grey_point_checker #(
    parameter int unsigned PIXEL_BITS = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    input  logic                           s_axis_tready,
    input  logic [gpt_pkg::FIELD_BITS-1:0] s_axis_tdata,  // [15:0] pixel_in
    input  logic                           s_axis_tlast,  // line_end_in
    input  logic                           s_axis_tuser,  // [0] frame_end_in
    input  logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    input  logic [gpt_pkg::FIELD_BITS-1:0] m_axis_tdata,  // [15:0] pixel_out
    input  logic                           m_axis_tlast,  // line_end_out
    input  logic                           m_axis_tuser,  // [0] frame_end_out
    input  logic                           i_cfg_we,
    input  logic [gpt_pkg::IDX_BITS-1:0]   i_cfg_idx,
    input  logic [gpt_pkg::CFG_BITS-1:0]   i_cfg_data,
    output int                             o_fail_count,
    output int                             o_pending
);
    import gpt_pkg::*;

    typedef struct packed {
        logic [15:0] pixel;
        logic        line_end;
        logic        frame_end;
    } t_grey_word;

    t_grey_word  words_due[$];
    int          fail_total = 0;

    // register mirror
    logic [2:0]  cur_mode;
    logic [15:0] cur_max;
    logic [15:0] cur_black;
    logic [15:0] cur_white;
    logic [15:0] cur_thresh;

    assign o_fail_count = fail_total;

    function automatic logic [15:0] map_grey(input logic [2:0] mode, input logic [15:0] px,
                                             input logic [15:0] grey_max, input logic [15:0] black,
                                             input logic [15:0] white, input logic [15:0] thresh);
        logic [15:0] mask;
        logic [15:0] p, m, b, w, t;
        logic [15:0] diff, span;
        logic [31:0] scaled;
        logic [15:0] res;
        mask = 16'((32'd1 << PIXEL_BITS) - 32'd1);
        p = px & mask;
        m = grey_max & mask;
        b = black & mask;
        w = white & mask;
        t = thresh & mask;
        case (mode)
            MODE_NEGATIVE: res = (p <= m) ? m - p : 16'd0;
            MODE_LEVELS: begin
                if (p <= b) begin
                    res = 16'd0;
                end else if (p < w) begin
                    diff   = p - b;
                    span   = w - b;
                    scaled = (32'(diff) * 32'(m)) / 32'(span);
                    res    = scaled[15:0];
                end else begin
                    res = m;
                end
            end
            MODE_THRESH:   res = (p <= t) ? 16'd0 : m;
            MODE_HT_BLACK: res = (p <= t) ? 16'd0 : p;
            MODE_HT_WHITE: res = (p <= t) ? p : m;
            default:       res = p;
        endcase
        return res & mask;
    endfunction

    task automatic log_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        fail_total++;
    endtask

    always @(posedge i_clk) begin
        t_grey_word due;
        t_grey_word got;
        if (!i_rst_n) begin
            cur_mode   = MODE_NEGATIVE;
            cur_max    = 16'd255;
            cur_black  = 16'd0;
            cur_white  = 16'd255;
            cur_thresh = 16'd127;
            words_due.delete();
        end else begin
            // check before queueing: a word accepted now cannot already be on the master side
            if (m_axis_tvalid && m_axis_tready) begin
                got = '{m_axis_tdata[15:0], m_axis_tlast, m_axis_tuser};
                if (words_due.size() == 0) begin
                    log_mismatch($sformatf("unexpected word pixel %0d last %0b user %0b",
                                           got.pixel, got.line_end, got.frame_end));
                end else begin
                    due = words_due.pop_front();
                    if (got.pixel !== due.pixel)
                        log_mismatch($sformatf("pixel_out %0d, want %0d", got.pixel, due.pixel));
                    if (got.line_end !== due.line_end)
                        log_mismatch($sformatf("line_end_out %0b, want %0b",
                                               got.line_end, due.line_end));
                    if (got.frame_end !== due.frame_end)
                        log_mismatch($sformatf("frame_end_out %0b, want %0b",
                                               got.frame_end, due.frame_end));
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                due.pixel     = map_grey(cur_mode, s_axis_tdata[15:0], cur_max, cur_black,
                                         cur_white, cur_thresh);
                due.line_end  = s_axis_tlast;
                due.frame_end = s_axis_tuser;
                words_due.push_back(due);
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_MODE:      cur_mode   = i_cfg_data[2:0];
                    CFG_MAX_GREY:  cur_max    = i_cfg_data[15:0];
                    CFG_BLACK:     cur_black  = i_cfg_data[15:0];
                    CFG_WHITE:     cur_white  = i_cfg_data[15:0];
                    CFG_THRESHOLD: cur_thresh = i_cfg_data[15:0];
                    default: ;
                endcase
            end
        end
        o_pending <= words_due.size();
    end

endmodule

// ===== dv/grey_point_transform_tb.sv =====
module grey_point_transform_tb;
    import gpt_pkg::*;

    localparam int unsigned PIXEL_BITS     = 16;
    localparam int          RESET_CYCLES   = 8;
    localparam int          RANDOM_PHASES  = 20;
    localparam int          PHASE_WORDS    = 68;
    localparam int          LONG_HOLD      = 160;   // receiver hold-off, well past pipe depth
    localparam int          WATCHDOG_LIMIT = 2000;  // cycles with no word moving and no register write

    // mode codes past the last defined one; the block passes the pixel through
    localparam logic [2:0]  MODE_SPARE_LO  = MODE_HT_WHITE + 3'd1;
    localparam logic [2:0]  MODE_SPARE_HI  = 3'd7;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;

    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [FIELD_BITS-1:0] s_axis_tdata = '0;
    logic                  s_axis_tlast = 1'b0;
    logic                  s_axis_tuser = 1'b0;

    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [FIELD_BITS-1:0] m_axis_tdata;
    logic                  m_axis_tlast;
    logic                  m_axis_tuser;

    logic                  cfg_we = 1'b0;
    logic [IDX_BITS-1:0]   cfg_idx = '0;
    logic [CFG_BITS-1:0]   cfg_data = '0;

    int                    fail_count;
    int                    pending;

    // settings last written, used only to aim pixels at the interesting edges
    logic [15:0]           cur_max = 16'd255;
    logic [15:0]           cur_black = 16'd0;
    logic [15:0]           cur_white = 16'd255;
    logic [15:0]           cur_thresh = 16'd127;

    // sender burst state
    int                    burst_left = 0;
    bit                    sender_gaps = 1'b1;

    // long receiver hold-off requests; the receiver counts the stretch itself
    int                    hold_reqs = 0;
    int                    hold_seen = 0;
    int                    hold_left = 0;
    int                    stall_style = 0;
    int                    style_left = 0;

    int                    quiet_cycles = 0;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    grey_point_transform #(
        .PIXEL_BITS(PIXEL_BITS)
    ) dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (cfg_we),
        .i_cfg_idx     (cfg_idx),
        .i_cfg_data    (cfg_data)
    );

    grey_point_checker #(
        .PIXEL_BITS(PIXEL_BITS)
    ) checker_i (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (cfg_we),
        .i_cfg_idx     (cfg_idx),
        .i_cfg_data    (cfg_data),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    // Receiver: a randomly drawn stall style, redrawn when its random stretch runs out,
    // overridden by a long hold-off when the stimulus asks for one.
    always @(posedge clk) begin
        if (hold_seen != hold_reqs) begin
            hold_seen = hold_reqs;
            hold_left = LONG_HOLD;
        end
        if (style_left == 0) begin
            stall_style = $urandom_range(0, 3);
            style_left  = $urandom_range(16, 96);
        end else begin
            style_left--;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            case (stall_style)
                0:       m_axis_tready <= 1'b1;                      // no stalls
                1:       m_axis_tready <= 1'($urandom_range(0, 1));  // coin toss
                2:       m_axis_tready <= ($urandom_range(0, 7) != 0);
                default: m_axis_tready <= ($urandom_range(0, 3) == 0); // mostly stalled
            endcase
        end
    end

    // Watchdog: any word on either side, or a register write, counts as progress.
    always @(posedge clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: nothing moved for %0d cycles", WATCHDOG_LIMIT);
            $display("grey_point_transform test failed");
            $finish;
        end
    end

    // Offer one word and hold it until taken. Bursts of random length, with
    // a random gap (sometimes none) before each burst when gaps are enabled.
    task automatic send_pixel(input logic [15:0] px, input logic line_end, input logic frame_end);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 48);
            if (sender_gaps) begin
                gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                if (gap > 0) begin
                    s_axis_tvalid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= px;
        s_axis_tlast  <= line_end;
        s_axis_tuser  <= frame_end;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        burst_left--;
    endtask

    // Stop offering and wait for every outstanding word to come out.
    // It waits for a clock edge first so the checker's count includes the last word taken.
    task automatic wait_drain();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    // Write all five registers back to back, pipe empty.
    task automatic apply_setting(input logic [2:0] mode, input logic [15:0] grey_max,
                                 input logic [15:0] black, input logic [15:0] white,
                                 input logic [15:0] thresh);
        logic [IDX_BITS-1:0] idx_list [5];
        logic [CFG_BITS-1:0] val_list [5];
        idx_list = '{CFG_MODE, CFG_MAX_GREY, CFG_BLACK, CFG_WHITE, CFG_THRESHOLD};
        val_list = '{CFG_BITS'(mode), grey_max, black, white, thresh};
        wait_drain();
        for (int k = 0; k < 5; k++) begin
            cfg_we   <= 1'b1;
            cfg_idx  <= idx_list[k];
            cfg_data <= val_list[k];
            @(posedge clk);
        end
        cfg_we     <= 1'b0;
        cur_max    = grey_max;
        cur_black  = black;
        cur_white  = white;
        cur_thresh = thresh;
    endtask

    // Random setting, leaning on the extremes and on the odd orderings of
    // black and white (equal, swapped, one to four apart).
    task automatic random_setting();
        int          r;
        logic [2:0]  mode;
        logic [15:0] gm, b, w, t, x, y;
        r    = $urandom_range(0, 15);
        mode = (r < 13) ? 3'(r % 5) : MODE_SPARE_LO + 3'($urandom_range(0, 2));
        case ($urandom_range(0, 4))
            0:       gm = 16'd1;
            1:       gm = 16'hFFFF;
            2:       gm = 16'd255;
            default: gm = 16'($urandom_range(1, 65535));
        endcase
        x = 16'($urandom());
        y = 16'($urandom());
        case ($urandom_range(0, 5))
            0: begin b = 16'd0; w = 16'hFFFF; end
            1: begin b = x; w = x; end
            2: begin b = (x > y) ? x : y; w = (x > y) ? y : x; end
            3: begin b = x; w = x + 16'($urandom_range(1, 4)); end
            default: begin b = (x < y) ? x : y; w = (x < y) ? y : x; end
        endcase
        case ($urandom_range(0, 3))
            0:       t = 16'd0;
            1:       t = 16'hFFFF;
            default: t = 16'($urandom());
        endcase
        apply_setting(mode, gm, b, w, t);
    endtask

    // Pixels aimed at the boundaries of the current setting, plus plain random.
    function automatic logic [15:0] pick_pixel();
        logic [15:0] nudge;
        nudge = 16'($urandom_range(0, 2)) - 16'd1;
        case ($urandom_range(0, 9))
            0:       return 16'd0;
            1:       return 16'hFFFF;
            2:       return cur_black + nudge;
            3:       return cur_white + nudge;
            4:       return cur_thresh + nudge;
            5:       return cur_max + nudge;
            default: return 16'($urandom());
        endcase
    endfunction

    // One phase of random words: mostly whole frames (rows closed by tlast,
    // the image closed by tuser), sometimes loose markers.
    task automatic random_phase(input int words, input bit loose_markers, input bit mid_pause);
        int sent;
        int cols, rows;
        sent = 0;
        while (sent < words) begin
            if (mid_pause && sent >= words / 2) begin
                wait_drain();
                mid_pause = 1'b0;
            end
            if (loose_markers) begin
                send_pixel(pick_pixel(), ($urandom_range(0, 3) == 0), ($urandom_range(0, 7) == 0));
                sent++;
            end else begin
                cols = $urandom_range(1, 12);
                rows = $urandom_range(1, 5);
                for (int row = 0; row < rows; row++) begin
                    for (int col = 0; col < cols; col++) begin
                        send_pixel(pick_pixel(), (col == cols - 1),
                                   (col == cols - 1) && (row == rows - 1));
                        sent++;
                    end
                end
            end
        end
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // --- directed ---
        // reset setting is negative with max 255: inside, at max, just past, top of range
        send_pixel(16'd0, 1'b0, 1'b0);
        send_pixel(16'd255, 1'b0, 1'b0);
        send_pixel(16'd256, 1'b1, 1'b0);
        send_pixel(16'hFFFF, 1'b1, 1'b1);

        // levels around both edges, widest max
        apply_setting(MODE_LEVELS, 16'hFFFF, 16'd100, 16'd200, 16'd127);
        send_pixel(16'd100, 1'b0, 1'b0);
        send_pixel(16'd101, 1'b0, 1'b0);
        send_pixel(16'd199, 1'b0, 1'b0);
        send_pixel(16'd200, 1'b0, 1'b0);
        send_pixel(16'd0, 1'b0, 1'b0);
        send_pixel(16'hFFFF, 1'b1, 1'b1);

        // levels with white equal to black, then white below black: no divide
        apply_setting(MODE_LEVELS, 16'd1000, 16'd500, 16'd500, 16'd127);
        send_pixel(16'd500, 1'b0, 1'b0);
        send_pixel(16'd501, 1'b1, 1'b0);
        apply_setting(MODE_LEVELS, 16'd1000, 16'd600, 16'd400, 16'd127);
        send_pixel(16'd500, 1'b0, 1'b0);
        send_pixel(16'd700, 1'b1, 1'b1);

        // thresholds at both ends of the range
        apply_setting(MODE_THRESH, 16'hFFFF, 16'd0, 16'd255, 16'd0);
        send_pixel(16'd0, 1'b0, 1'b0);
        send_pixel(16'd1, 1'b1, 1'b0);
        apply_setting(MODE_HT_BLACK, 16'd255, 16'd0, 16'd255, 16'hFFFF);
        send_pixel(16'hFFFF, 1'b1, 1'b1);
        apply_setting(MODE_HT_WHITE, 16'd2000, 16'd0, 16'd255, 16'd1000);
        send_pixel(16'd1000, 1'b0, 1'b0);
        send_pixel(16'd1001, 1'b1, 1'b0);

        // undefined mode code passes the pixel through
        apply_setting(MODE_SPARE_HI, 16'd255, 16'd0, 16'd255, 16'd127);
        send_pixel(16'd12345, 1'b0, 1'b1);

        // max grey of zero
        apply_setting(MODE_NEGATIVE, 16'd0, 16'd0, 16'd100, 16'd127);
        send_pixel(16'd0, 1'b0, 1'b0);
        send_pixel(16'd5, 1'b1, 1'b0);
        apply_setting(MODE_LEVELS, 16'd0, 16'd0, 16'd100, 16'd127);
        send_pixel(16'd50, 1'b1, 1'b1);

        // --- random phases ---
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            random_setting();
            sender_gaps = ($urandom_range(0, 3) != 0);
            if (phase == 3) begin
                // receiver holds off long enough for the pipe to fill and
                // back-pressure the sender, which keeps offering
                sender_gaps = 1'b0;
                hold_reqs <= hold_reqs + 1;
            end
            random_phase(PHASE_WORDS, ($urandom_range(0, 4) == 0),
                         (phase == 1) || ($urandom_range(0, 3) == 0));
        end

        wait_drain();
        repeat (PIXEL_BITS + 8) @(posedge clk);

        if (fail_count == 0 && pending == 0) begin
            $display("grey_point_transform test passed");
        end else begin
            $display("grey_point_transform test failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
src/gpt_pkg.sv
src/gpt_map.sv
src/gpt_mul.sv
src/gpt_div_stage.sv
src/grey_point_transform.sv
dv/grey_point_checker.sv
dv/grey_point_transform_tb.sv
